FILE: sv/hap_pkg.sv
// ----------------------------------------------------------------------------
// hap_pkg
// Shared types and constants for the handle pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hap_pkg;

  localparam int unsigned POOL_DEPTH = 64;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int unsigned HANDLE_W   = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned SIZE_W     = 7;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_LOAD    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_GRANTED  = 3'd0,
    STAT_REFUSED  = 3'd1,
    STAT_RELEASED = 3'd2,
    STAT_IGNORED  = 3'd3,
    STAT_LOADED   = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_e;

  typedef struct packed {
    req_e                  req_type;
    logic [COUNT_W-1:0]    count;
    logic [HANDLE_W-1:0]   handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   out_handle;
    status_e               status;
    logic                  last;
  } res_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Update of the in-use map
  typedef struct packed {
    logic  set;
    idx_t  set_idx;
    logic  clr;
    idx_t  clr_idx;
    logic  clr_all;
  } use_cmd_t;

endpackage

`default_nettype wire

FILE: sv/hap_ram.sv
// ----------------------------------------------------------------------------
// hap_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/hap_use_map.sv
// ----------------------------------------------------------------------------
// hap_use_map
// One in-use flag per handle, with set, clear and clear-all updates.
// ----------------------------------------------------------------------------
`default_nettype none

module hap_use_map (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hap_pkg::use_cmd_t cmd_i,
  input  wire hap_pkg::idx_t    query_idx_i,
  output      logic             hit_o
);

  logic [hap_pkg::POOL_DEPTH-1:0] used_q;
  logic [hap_pkg::POOL_DEPTH-1:0] used_d;

  always_comb begin
    used_d = used_q;
    if (cmd_i.clr_all) begin
      used_d = '0;
    end
    if (cmd_i.clr) begin
      used_d[cmd_i.clr_idx] = 1'b0;
    end
    if (cmd_i.set) begin
      used_d[cmd_i.set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign hit_o = used_q[query_idx_i];

endmodule

`default_nettype wire

FILE: sv/handle_pool_allocator.sv
// Release, refused, empty and ignored answers: one registered result in the cycle
// after acceptance; the next transaction may follow in the next cycle.
// Allocate of n handles: busy while grants come out, one per cycle, each via the
// registered read of the free-stack RAM's single read port, which paces them.
// Load of n handles: stack writes, handle i to entry i, then the loaded result.
// Reset: pool empty, all handles free of use, pool_size 64. Results cannot stall.
// ----------------------------------------------------------------------------
// handle_pool_allocator
// Free-list object pool: LIFO stack of free handles in RAM plus in-use flags.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_pool_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire hap_pkg::req_t                 req_i,
  output      logic                          res_valid_o,
  output      hap_pkg::res_t                 res_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [hap_pkg::SIZE_W-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_LOAD
  } state_e;

  localparam int unsigned IDX_W = hap_pkg::IDX_W;
  localparam int unsigned CNT_W = hap_pkg::CNT_W;

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            fc_q, fc_d;
  logic [CNT_W-1:0]            rem_q, rem_d;
  hap_pkg::idx_t               idx_q, idx_d;
  hap_pkg::idx_t               ld_last_q, ld_last_d;
  logic [hap_pkg::SIZE_W-1:0]  pool_size_q;
  hap_pkg::res_t               res_q, res_d;
  logic                        res_vld_q, res_vld_d;

  logic                        accept;
  logic [CNT_W-1:0]            fc_dec;
  logic [CNT_W-1:0]            load_n;

  logic                        ram_we;
  hap_pkg::idx_t               ram_waddr;
  logic [hap_pkg::HANDLE_W-1:0] ram_wdata;
  logic                        ram_re;
  hap_pkg::idx_t               ram_raddr;
  logic [hap_pkg::HANDLE_W-1:0] ram_rdata;

  hap_pkg::use_cmd_t           use_cmd;
  logic                        use_hit;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign fc_dec      = fc_q - CNT_W'(1);
  assign load_n      = (pool_size_q > hap_pkg::SIZE_W'(hap_pkg::POOL_DEPTH))
                       ? CNT_W'(hap_pkg::POOL_DEPTH) : CNT_W'(pool_size_q);

  hap_ram #(
    .WIDTH (hap_pkg::HANDLE_W),
    .DEPTH (hap_pkg::POOL_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hap_use_map u_use_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (use_cmd),
    .query_idx_i (req_i.handle[IDX_W-1:0]),
    .hit_o       (use_hit)
  );

  always_comb begin
    state_d   = state_q;
    fc_d      = fc_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    ld_last_d = ld_last_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fc_q[IDX_W-1:0];
    ram_wdata = req_i.handle;
    ram_re    = 1'b0;
    ram_raddr = fc_dec[IDX_W-1:0];
    use_cmd   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            hap_pkg::REQ_ALLOC: begin
              res_d.out_handle = '0;
              res_d.last       = 1'b1;
              if (req_i.count == '0) begin
                res_vld_d    = 1'b1;
                res_d.status = hap_pkg::STAT_EMPTY;
              end else if (req_i.count > hap_pkg::COUNT_W'(fc_q)) begin
                res_vld_d    = 1'b1;
                res_d.status = hap_pkg::STAT_REFUSED;
              end else begin
                // issue the first pop; data returns next cycle
                ram_re  = 1'b1;
                fc_d    = fc_dec;
                rem_d   = CNT_W'(req_i.count - hap_pkg::COUNT_W'(1));
                state_d = S_ALLOC;
              end
            end
            hap_pkg::REQ_RELEASE: begin
              res_vld_d  = 1'b1;
              res_d.last = 1'b1;
              if ((hap_pkg::COUNT_W'(req_i.handle) < hap_pkg::COUNT_W'(hap_pkg::POOL_DEPTH))
                  && use_hit && (fc_q < CNT_W'(hap_pkg::POOL_DEPTH))) begin
                ram_we           = 1'b1;
                fc_d             = fc_q + CNT_W'(1);
                use_cmd.clr      = 1'b1;
                use_cmd.clr_idx  = req_i.handle[IDX_W-1:0];
                res_d.out_handle = req_i.handle;
                res_d.status     = hap_pkg::STAT_RELEASED;
              end else begin
                res_d.out_handle = '0;
                res_d.status     = hap_pkg::STAT_IGNORED;
              end
            end
            hap_pkg::REQ_LOAD: begin
              use_cmd.clr_all  = 1'b1;
              fc_d             = load_n;
              res_d.out_handle = '0;
              res_d.status     = hap_pkg::STAT_LOADED;
              res_d.last       = 1'b1;
              if (load_n == '0) begin
                res_vld_d = 1'b1;
              end else begin
                idx_d     = '0;
                ld_last_d = IDX_W'(load_n - CNT_W'(1));
                state_d   = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        res_vld_d        = 1'b1;
        res_d.out_handle = ram_rdata;
        res_d.status     = hap_pkg::STAT_GRANTED;
        res_d.last       = (rem_q == '0);
        use_cmd.set      = 1'b1;
        use_cmd.set_idx  = ram_rdata[IDX_W-1:0];
        if (rem_q != '0) begin
          ram_re = 1'b1;
          fc_d   = fc_dec;
          rem_d  = rem_q - CNT_W'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        // sweep handle i into stack entry i
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = hap_pkg::HANDLE_W'(idx_q);
        if (idx_q == ld_last_q) begin
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      ld_last_q   <= '0;
      pool_size_q <= hap_pkg::SIZE_W'(64);
      res_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      fc_q      <= fc_d;
      rem_q     <= rem_d;
      idx_q     <= idx_d;
      ld_last_q <= ld_last_d;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pool_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CNT_W'(hap_pkg::POOL_DEPTH))
    else $error("free count above pool depth");

  a_alloc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && rem_q != '0) |=> (state_q == S_ALLOC))
    else $error("batch allocate left early");

  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type != hap_pkg::REQ_NONE) |=> (res_vld_q || state_q != S_IDLE))
    else $error("accepted transaction produced no answer");

  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_q.last) |-> (state_q == S_ALLOC))
    else $error("non-final result outside batch allocate");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the handle pool allocator. A directed walk through
// the corner cases is followed by blocks of random pool traffic. Each block
// starts with a fresh pool size and a load. Every answer is checked against a
// behavioural copy of the free stack and the in-use flags.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASES         = 3;
  localparam int unsigned BLOCKS         = 4;
  localparam int unsigned BLOCK_ITEMS    = 33;

  typedef struct {
    logic                       cfg_write;
    logic [hap_pkg::SIZE_W-1:0] cfg_value;
    hap_pkg::req_t              req;
    logic                       typed;
    hap_pkg::res_t              want;
  } step_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  hap_pkg::req_t              req_i       = '0;
  logic                       res_valid_o;
  hap_pkg::res_t              res_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [hap_pkg::SIZE_W-1:0] cfg_data_i  = '0;

  // Behavioural copy of the pool
  logic [hap_pkg::HANDLE_W-1:0]   pool_stack [hap_pkg::POOL_DEPTH];
  int unsigned                    pool_free   = 0;
  logic [hap_pkg::POOL_DEPTH-1:0] pool_in_use = '0;
  logic [hap_pkg::SIZE_W-1:0]     pool_size_q = hap_pkg::SIZE_W'(hap_pkg::POOL_DEPTH);
  hap_pkg::res_t                  awaited_answers [$];

  step_t         directed_steps [$];
  hap_pkg::res_t last_seen    = '0;
  int unsigned   errors       = 0;
  int unsigned   n_requests   = 0;
  int unsigned   n_answers    = 0;
  int unsigned   n_grants     = 0;
  int unsigned   n_cfg        = 0;
  int unsigned   quiet_cycles = 0;

  handle_pool_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic hap_pkg::res_t answer(int unsigned h, hap_pkg::status_e st, logic lst);
    hap_pkg::res_t a;
    a.out_handle = hap_pkg::HANDLE_W'(h);
    a.status     = st;
    a.last       = lst;
    return a;
  endfunction

  // Append one answer to the tail of the awaited queue
  function automatic void await_answer(hap_pkg::res_t a);
    awaited_answers.insert(awaited_answers.size(), a);
  endfunction

  function automatic void compare_answer(string tag, hap_pkg::res_t want,
                                         hap_pkg::res_t got);
    if (got.out_handle !== want.out_handle) begin
      errors++;
      $display("%0t: %s out_handle expected %0d actual %0d", $time, tag,
               want.out_handle, got.out_handle);
    end
    if (got.status !== want.status) begin
      errors++;
      $display("%0t: %s status expected %0d actual %0d", $time, tag,
               want.status, got.status);
    end
    if (got.last !== want.last) begin
      errors++;
      $display("%0t: %s last expected %0d actual %0d", $time, tag, want.last, got.last);
    end
  endfunction

  // Work out the answers to one accepted transaction and advance the pool copy
  function automatic void predict_answers(hap_pkg::req_t r);
    int unsigned                  n;
    logic [hap_pkg::HANDLE_W-1:0] got;
    case (r.req_type)
      hap_pkg::REQ_ALLOC: begin
        if (r.count == '0) begin
          await_answer(answer(0, hap_pkg::STAT_EMPTY, 1'b1));
        end else if (r.count > pool_free || r.count > hap_pkg::POOL_DEPTH) begin
          await_answer(answer(0, hap_pkg::STAT_REFUSED, 1'b1));
        end else begin
          n = r.count;
          for (int unsigned i = 0; i < n; i++) begin
            pool_free--;
            got = pool_stack[pool_free];
            pool_in_use[got] = 1'b1;
            await_answer(answer(got, hap_pkg::STAT_GRANTED, i + 1 == n));
          end
        end
      end
      hap_pkg::REQ_RELEASE: begin
        if (pool_in_use[r.handle] && pool_free < hap_pkg::POOL_DEPTH) begin
          pool_in_use[r.handle] = 1'b0;
          pool_stack[pool_free] = r.handle;
          pool_free++;
          await_answer(answer(r.handle, hap_pkg::STAT_RELEASED, 1'b1));
        end else begin
          await_answer(answer(0, hap_pkg::STAT_IGNORED, 1'b1));
        end
      end
      hap_pkg::REQ_LOAD: begin
        n = (pool_size_q > hap_pkg::POOL_DEPTH) ? hap_pkg::POOL_DEPTH : pool_size_q;
        pool_in_use = '0;
        for (int unsigned i = 0; i < n; i++) pool_stack[i] = hap_pkg::HANDLE_W'(i);
        pool_free = n;
        await_answer(answer(0, hap_pkg::STAT_LOADED, 1'b1));
      end
      default: begin
        // unused request type: no answer, nothing changes
      end
    endcase
  endfunction

  // Mostly well-formed traffic: small allocations and releases of live handles
  function automatic hap_pkg::req_t pick_request();
    hap_pkg::req_t r;
    int unsigned   roll;
    int unsigned   first;
    roll     = $urandom_range(99);
    r.count  = hap_pkg::COUNT_W'($urandom_range(127));
    r.handle = hap_pkg::HANDLE_W'($urandom_range(hap_pkg::POOL_DEPTH - 1));
    if (roll < 45) begin
      r.req_type = hap_pkg::REQ_ALLOC;
      case ($urandom_range(9))
        7: r.count = '0;
        8: ; // keep the wide count, mostly refused
        9: r.count = hap_pkg::COUNT_W'(pool_free);
        default: r.count = hap_pkg::COUNT_W'($urandom_range(1, 4));
      endcase
    end else if (roll < 88) begin
      r.req_type = hap_pkg::REQ_RELEASE;
      if (pool_in_use != '0 && $urandom_range(4) != 0) begin
        first = $urandom_range(hap_pkg::POOL_DEPTH - 1);
        for (int unsigned i = 0; i < hap_pkg::POOL_DEPTH; i++) begin
          if (pool_in_use[(first + i) % hap_pkg::POOL_DEPTH]) begin
            r.handle = hap_pkg::HANDLE_W'((first + i) % hap_pkg::POOL_DEPTH);
            break;
          end
        end
      end
    end else if (roll < 95) begin
      r.req_type = hap_pkg::REQ_LOAD;
    end else begin
      r.req_type = hap_pkg::REQ_NONE;
    end
    return r;
  endfunction

  function automatic void req_row(hap_pkg::req_e t, int unsigned c, int unsigned h,
                                  logic typed, hap_pkg::res_t want);
    step_t s;
    s.cfg_write      = 1'b0;
    s.cfg_value      = '0;
    s.req.req_type   = t;
    s.req.count      = hap_pkg::COUNT_W'(c);
    s.req.handle     = hap_pkg::HANDLE_W'(h);
    s.typed          = typed;
    s.want           = want;
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic void cfg_row(int unsigned v);
    step_t s;
    s = '{cfg_write: 1'b1, cfg_value: hap_pkg::SIZE_W'(v), req: '0, typed: 1'b0,
          want: '0};
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  task automatic issue_request(input hap_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_pool_size(input logic [hap_pkg::SIZE_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every awaited answer is in and the block is idle
  task automatic drain_answers();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Answer checking, prediction and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        if (awaited_answers.size() == 0) begin
          errors++;
          $display("%0t: stray answer, expected none, actual handle %0d status %0d last %0d",
                   $time, res_o.out_handle, res_o.status, res_o.last);
        end else begin
          compare_answer("answer", awaited_answers.pop_front(), res_o);
        end
        last_seen = res_o;
        n_answers++;
        if (res_o.status == hap_pkg::STAT_GRANTED) n_grants++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pool_size_q = cfg_data_i;
        n_cfg++;
      end
      if (start && !busy) begin
        predict_answers(req_i);
        n_requests++;
      end
      if (res_valid_o || (cfg_valid_i && cfg_ready_o) || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("** handle_pool_allocator: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned                idle_plan [PHASES];
    logic [hap_pkg::SIZE_W-1:0] size_plan [$];
    logic [hap_pkg::SIZE_W-1:0] next_size;
    int unsigned                blk;
    hap_pkg::req_t              load_req;

    idle_plan = '{19, 70, 0};
    size_plan = '{7'd64, 7'd127, 7'd5, 7'd0, 7'd96, 7'd1};
    load_req  = '0;
    load_req.req_type = hap_pkg::REQ_LOAD;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pool is empty straight after reset
    req_row(hap_pkg::REQ_ALLOC,   1,   0,  1'b1, answer(0, hap_pkg::STAT_REFUSED, 1'b1));
    req_row(hap_pkg::REQ_RELEASE, 0,   0,  1'b1, answer(0, hap_pkg::STAT_IGNORED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   0,   0,  1'b1, answer(0, hap_pkg::STAT_EMPTY, 1'b1));
    req_row(hap_pkg::REQ_NONE,    127, 63, 1'b0, '0);
    req_row(hap_pkg::REQ_LOAD,    0,   0,  1'b1, answer(0, hap_pkg::STAT_LOADED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   1,   0,  1'b1, answer(63, hap_pkg::STAT_GRANTED, 1'b1));
    req_row(hap_pkg::REQ_RELEASE, 0,   63, 1'b1, answer(63, hap_pkg::STAT_RELEASED, 1'b1));
    // second release of a free handle
    req_row(hap_pkg::REQ_RELEASE, 0,   63, 1'b1, answer(0, hap_pkg::STAT_IGNORED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   65,  0,  1'b1, answer(0, hap_pkg::STAT_REFUSED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   127, 63, 1'b1, answer(0, hap_pkg::STAT_REFUSED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   64,  0,  1'b0, '0);
    req_row(hap_pkg::REQ_ALLOC,   1,   0,  1'b1, answer(0, hap_pkg::STAT_REFUSED, 1'b1));
    req_row(hap_pkg::REQ_RELEASE, 127, 0,  1'b1, answer(0, hap_pkg::STAT_RELEASED, 1'b1));
    req_row(hap_pkg::REQ_RELEASE, 0,   63, 1'b1, answer(63, hap_pkg::STAT_RELEASED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   2,   0,  1'b0, '0);
    // zero pool size still answers loaded
    cfg_row(0);
    req_row(hap_pkg::REQ_LOAD,    0,   0,  1'b1, answer(0, hap_pkg::STAT_LOADED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   1,   0,  1'b1, answer(0, hap_pkg::STAT_REFUSED, 1'b1));
    // oversized pool size is clipped to the depth
    cfg_row(127);
    req_row(hap_pkg::REQ_LOAD,    0,   0,  1'b1, answer(0, hap_pkg::STAT_LOADED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   64,  0,  1'b0, '0);
    cfg_row(1);
    req_row(hap_pkg::REQ_LOAD,    0,   0,  1'b1, answer(0, hap_pkg::STAT_LOADED, 1'b1));
    req_row(hap_pkg::REQ_ALLOC,   1,   0,  1'b1, answer(0, hap_pkg::STAT_GRANTED, 1'b1));
    // handle outside the last load
    req_row(hap_pkg::REQ_RELEASE, 0,   42, 1'b1, answer(0, hap_pkg::STAT_IGNORED, 1'b1));

    foreach (directed_steps[k]) begin
      if (directed_steps[k].cfg_write) write_pool_size(directed_steps[k].cfg_value);
      else issue_request(directed_steps[k].req);
      drain_answers();
      if (directed_steps[k].typed) begin
        compare_answer($sformatf("directed step %0d", k), directed_steps[k].want, last_seen);
      end
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      for (int unsigned b = 0; b < BLOCKS; b++) begin
        blk = ph * BLOCKS + b;
        drain_answers();
        next_size = (blk < size_plan.size()) ? size_plan[blk]
                                             : hap_pkg::SIZE_W'($urandom_range(1, 127));
        write_pool_size(next_size);
        issue_request(load_req);
        for (int unsigned i = 0; i < BLOCK_ITEMS; i++) begin
          // idle cycle by cycle so the gap share matches the plan
          while ($urandom_range(99) < idle_plan[ph]) begin
            start <= 1'b0;
            @(posedge clk_i);
          end
          issue_request(pick_request());
        end
      end
    end
    drain_answers();

    $display("Covered %0d requests, %0d answers (%0d grants) and %0d pool size writes,",
             n_requests, n_answers, n_grants, n_cfg);
    $display("with sender gaps at 19%%, then 70%%, then back to back.");
    if (errors == 0) begin
      $display("** handle_pool_allocator: PASSED **");
    end else begin
      $display("** handle_pool_allocator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/hap_pkg.sv
sv/hap_ram.sv
sv/hap_use_map.sv
sv/handle_pool_allocator.sv
sim/testbench.sv
